// ===== sv/fmcr_pkg.sv =====
package fmcr_pkg;

   // Sizing
   localparam int MAX_MOTORS = 8;
   localparam int IDX_W      = $clog2(MAX_MOTORS);
   localparam int CNT_W      = $clog2(MAX_MOTORS + 1);
   localparam int BIDX_W     = $clog2(2 * MAX_MOTORS + 2);
   localparam int ELAPSED_W  = 17;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

   // Register reset values
   localparam logic [3:0]  NUM_MOTORS_RST = 4'd8;
   localparam logic [7:0]  START_BYTE_RST = 8'd0;
   localparam logic [15:0] NEUTRAL_RST    = 16'd0;
   localparam logic [15:0] TIMEOUT_RST    = 16'd1000;

   typedef enum logic [1:0] {
      KIND_MOTOR   = 2'd0,
      KIND_ERROR   = 2'd1,
      KIND_NEUTRAL = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_NUM_MOTORS = 2'd0,
      CSR_START_BYTE = 2'd1,
      CSR_NEUTRAL    = 2'd2,
      CSR_TIMEOUT    = 2'd3
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } emit_state_type;

   // Request from the frame parser to the result sequencer
   typedef struct packed {
      logic     start;
      kind_type kind;
   } emit_cmd_type;

   // Write into the motor value store
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [15:0]      data;
   } store_wr_type;

   // Clamp the configured count to 1..MAX_MOTORS
   function automatic logic [CNT_W-1:0] motor_count(input logic [3:0] num);
      logic [CNT_W-1:0] n;
      n = CNT_W'(num);
      if (num == 4'd0) begin
         n = CNT_W'(1);
      end else if (32'(num) > MAX_MOTORS) begin
         n = CNT_W'(MAX_MOTORS);
      end
      return n;
   endfunction

endpackage

// ===== sv/fmcr_store.sv =====
module fmcr_store (
   input  logic                          clock,
   input  fmcr_pkg::store_wr_type        wr,
   input  logic [fmcr_pkg::IDX_W-1:0]    rd_addr,
   output logic [15:0]                   rd_data
);

   logic [15:0] value_ff [fmcr_pkg::MAX_MOTORS];

   // Capture a decoded motor value
   always_ff @(posedge clock) begin
      if (wr.en) begin
         value_ff[wr.addr] <= wr.data;
      end
   end

   // Read the entry under emission
   assign rd_data = value_ff[rd_addr];

endmodule

// ===== sv/fmcr_frame.sv =====
module fmcr_frame (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          action,
   input  logic [7:0]                    data_byte,
   input  logic [fmcr_pkg::CNT_W-1:0]    count,
   input  logic [7:0]                    start_byte,
   input  logic [15:0]                   timeout_ms,
   output fmcr_pkg::store_wr_type        store_wr,
   output fmcr_pkg::emit_cmd_type        cmd
);

   logic [fmcr_pkg::BIDX_W-1:0]    bidx_ff, bidx_in;
   logic [7:0]                     xor_ff, xor_in;
   logic [7:0]                     low_ff, low_in;
   logic [fmcr_pkg::ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                           timed_out_ff, timed_out_in;

   logic [fmcr_pkg::ELAPSED_W-1:0] elapsed_inc;
   logic [fmcr_pkg::BIDX_W-1:0]    check_pos;

   assign elapsed_inc = (elapsed_ff == fmcr_pkg::ELAPSED_MAX) ? elapsed_ff
                                                              : elapsed_ff + 1'b1;
   assign check_pos   = fmcr_pkg::BIDX_W'({count, 1'b1});

   // Parse one byte or tick
   always_comb begin
      bidx_in      = bidx_ff;
      xor_in       = xor_ff;
      low_in       = low_ff;
      elapsed_in   = elapsed_ff;
      timed_out_in = timed_out_ff;
      store_wr     = '0;
      cmd          = '0;
      if (accept) begin
         if (action) begin
            // Tick: count up, abandon the frame once past the timeout
            elapsed_in = elapsed_inc;
            if (elapsed_inc > fmcr_pkg::ELAPSED_W'(timeout_ms)) begin
               bidx_in = '0;
               xor_in  = '0;
               if (!timed_out_ff) begin
                  timed_out_in = 1'b1;
                  cmd.start    = 1'b1;
                  cmd.kind     = fmcr_pkg::KIND_NEUTRAL;
               end
            end
         end else if (bidx_ff == '0) begin
            // Hunt for the start byte
            if (data_byte == start_byte) begin
               xor_in  = data_byte;
               bidx_in = fmcr_pkg::BIDX_W'(1);
            end
         end else if (bidx_ff < check_pos) begin
            // Payload byte: low half held, high half completes a value
            xor_in = xor_ff ^ data_byte;
            if (bidx_ff[0]) begin
               low_in = data_byte;
            end else begin
               store_wr.en   = 1'b1;
               store_wr.addr = fmcr_pkg::IDX_W'(bidx_ff[fmcr_pkg::IDX_W:1] - 1'b1);
               store_wr.data = {data_byte, low_ff};
            end
            bidx_in = bidx_ff + 1'b1;
         end else begin
            // Checksum byte closes the frame
            bidx_in   = '0;
            xor_in    = '0;
            cmd.start = 1'b1;
            if (data_byte != xor_ff) begin
               cmd.kind = fmcr_pkg::KIND_ERROR;
            end else begin
               cmd.kind     = fmcr_pkg::KIND_MOTOR;
               elapsed_in   = '0;
               timed_out_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bidx_ff      <= '0;
         xor_ff       <= '0;
         low_ff       <= '0;
         elapsed_ff   <= '0;
         timed_out_ff <= 1'b0;
      end else begin
         bidx_ff      <= bidx_in;
         xor_ff       <= xor_in;
         low_ff       <= low_in;
         elapsed_ff   <= elapsed_in;
         timed_out_ff <= timed_out_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_bidx_range: assert property (@(posedge clock) disable iff (reset)
      bidx_ff <= fmcr_pkg::BIDX_W'(2 * fmcr_pkg::MAX_MOTORS + 1))
      else $error("frame position out of range");

   a_timeout_on_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(timed_out_ff) |-> $past(accept && action))
      else $error("timeout set without a tick");

   a_good_frame_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.start && cmd.kind == fmcr_pkg::KIND_MOTOR |=> elapsed_ff == '0 && !timed_out_ff)
      else $error("good frame did not clear the timer");
`endif

endmodule

// ===== sv/fmcr_emit.sv =====
module fmcr_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  fmcr_pkg::emit_cmd_type        cmd,
   input  logic [fmcr_pkg::CNT_W-1:0]    count,
   input  logic [15:0]                   safe_value,
   input  logic [15:0]                   rd_data,
   output logic [fmcr_pkg::IDX_W-1:0]    rd_addr,
   output logic                          idle,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_kind,
   output logic [2:0]                    rsp_motor_index,
   output logic [15:0]                   rsp_motor_value,
   output logic                          rsp_last
);

   fmcr_pkg::emit_state_type      state_ff, state_in;
   fmcr_pkg::kind_type            kind_ff, kind_in;
   logic [fmcr_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [fmcr_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   fmcr_pkg::kind_type            rsp_kind_ff, rsp_kind_in;
   logic [fmcr_pkg::IDX_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic [15:0]                   rsp_value_ff, rsp_value_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic out_free;
   logic load;
   logic idx_last;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign idx_last = (fmcr_pkg::CNT_W'(idx_ff) + 1'b1 == cnt_ff)
                     || (kind_ff == fmcr_pkg::KIND_ERROR);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fmcr_pkg::ST_IDLE: begin
            if (cmd.start) begin
               state_in = fmcr_pkg::ST_EMIT;
            end
         end
         fmcr_pkg::ST_EMIT: begin
            if (out_free && idx_last) begin
               state_in = fmcr_pkg::ST_IDLE;
            end
         end
         default: state_in = fmcr_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      idle = 1'b0;
      load = 1'b0;
      case (state_ff)
         fmcr_pkg::ST_IDLE: idle = 1'b1;
         fmcr_pkg::ST_EMIT: load = out_free;
         default:           idle = 1'b0;
      endcase
   end

   assign rd_addr = idx_ff;

   // Run counter and output register
   always_comb begin
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (idle && cmd.start) begin
         kind_in = cmd.kind;
         cnt_in  = count;
         idx_in  = '0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = kind_ff;
         rsp_idx_in   = idx_ff;
         rsp_last_in  = idx_last;
         idx_in       = idx_ff + 1'b1;
         case (kind_ff)
            fmcr_pkg::KIND_MOTOR:   rsp_value_in = rd_data;
            fmcr_pkg::KIND_NEUTRAL: rsp_value_in = safe_value;
            default:                rsp_value_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fmcr_pkg::ST_IDLE;
         kind_ff      <= fmcr_pkg::KIND_MOTOR;
         idx_ff       <= '0;
         cnt_ff       <= fmcr_pkg::CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_motor_index = 3'(rsp_idx_ff);
   assign rsp_motor_value = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> state_ff == fmcr_pkg::ST_IDLE)
      else $error("run requested while busy");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == fmcr_pkg::KIND_ERROR |-> rsp_last_ff && rsp_idx_ff == '0)
      else $error("checksum error result malformed");

   a_index_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> fmcr_pkg::CNT_W'(rsp_idx_ff) < cnt_ff)
      else $error("motor index past run length");
`endif

endmodule

// ===== sv/framed_motor_command_receiver.sv =====
// A byte or tick that yields no result is taken and ready stays high.
// A closing transfer or a timeout tick starts a run of results, loaded into the output register
// one result per cycle, stalled only by rsp_ready; req_ready stays low until the last result
// of the run has been loaded into the output register.
// Reset: synchronous, active high; clears frame position, checksum, timer, timed-out flag
// and restores register defaults. The motor value store is not cleared.
module framed_motor_command_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_motor_index,
   output logic [15:0] rsp_motor_value,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [3:0]  num_motors_ff;
   logic [7:0]  start_byte_ff;
   logic [15:0] neutral_ff;
   logic [15:0] timeout_ff;

   logic [fmcr_pkg::CNT_W-1:0] count;
   logic                       accept;
   logic                       idle;
   fmcr_pkg::store_wr_type     store_wr;
   fmcr_pkg::emit_cmd_type     cmd;
   logic [fmcr_pkg::IDX_W-1:0] rd_addr;
   logic [15:0]                rd_data;

   // Register writes always complete
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_motors_ff <= fmcr_pkg::NUM_MOTORS_RST;
         start_byte_ff <= fmcr_pkg::START_BYTE_RST;
         neutral_ff    <= fmcr_pkg::NEUTRAL_RST;
         timeout_ff    <= fmcr_pkg::TIMEOUT_RST;
      end else if (csr_valid) begin
         case (fmcr_pkg::csr_index_type'(csr_index))
            fmcr_pkg::CSR_NUM_MOTORS: num_motors_ff <= csr_wdata[3:0];
            fmcr_pkg::CSR_START_BYTE: start_byte_ff <= csr_wdata[7:0];
            fmcr_pkg::CSR_NEUTRAL:    neutral_ff    <= csr_wdata;
            fmcr_pkg::CSR_TIMEOUT:    timeout_ff    <= csr_wdata;
            default:                  num_motors_ff <= num_motors_ff;
         endcase
      end
   end

   assign count     = fmcr_pkg::motor_count(num_motors_ff);
   assign req_ready = idle;
   assign accept    = req_valid && req_ready;

   fmcr_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .action     (req_action),
      .data_byte  (req_data_byte),
      .count      (count),
      .start_byte (start_byte_ff),
      .timeout_ms (timeout_ff),
      .store_wr   (store_wr),
      .cmd        (cmd)
   );

   fmcr_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fmcr_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .count           (count),
      .safe_value      (neutral_ff),
      .rd_data         (rd_data),
      .rd_addr         (rd_addr),
      .idle            (idle),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_motor_index (rsp_motor_index),
      .rsp_motor_value (rsp_motor_value),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== sim/framed_motor_command_receiver_tb.sv =====
`timescale 1ns / 100ps

module framed_motor_command_receiver_tb;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
   } serial_item_type;

   typedef struct packed {
      fmcr_pkg::kind_type kind;
      logic [2:0]         motor_index;
      logic [15:0]        motor_value;
      logic               last;
   } motor_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = 1'b0;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [2:0]  rsp_motor_index;
   logic [15:0] rsp_motor_value;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = fmcr_pkg::CSR_NUM_MOTORS;
   logic [15:0] csr_wdata = 16'd0;

   // Bytes and ticks waiting to be driven, results waiting to come out
   serial_item_type  serial_backlog[$];
   motor_result_type due_results[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;

   // Register copies
   logic [3:0]  cfg_num_motors = fmcr_pkg::NUM_MOTORS_RST;
   logic [7:0]  cfg_start = fmcr_pkg::START_BYTE_RST;
   logic [15:0] cfg_neutral = fmcr_pkg::NEUTRAL_RST;
   logic [15:0] cfg_timeout = fmcr_pkg::TIMEOUT_RST;

   // Receiver state copies
   logic [4:0]  frame_pos = '0;
   logic [7:0]  frame_xor = '0;
   logic [15:0] motor_values[fmcr_pkg::MAX_MOTORS];
   logic [7:0]  held_low = '0;
   logic [16:0] tick_count = '0;
   logic        in_timeout = 1'b0;

   framed_motor_command_receiver i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_motor_index (rsp_motor_index),
      .rsp_motor_value (rsp_motor_value),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      if (mismatch_count < 100) begin
         $display("ERROR %0t: %s", $time, what);
      end
      mismatch_count++;
   endtask

   // Clamp the configured count to 1..MAX_MOTORS
   function automatic int active_motor_count();
      if (cfg_num_motors == 4'd0) begin
         return 1;
      end
      if (int'(cfg_num_motors) > fmcr_pkg::MAX_MOTORS) begin
         return fmcr_pkg::MAX_MOTORS;
      end
      return int'(cfg_num_motors);
   endfunction

   function automatic void push_result(input fmcr_pkg::kind_type kind, input int motor,
                                       input logic [15:0] value, input bit is_last);
      motor_result_type entry;
      entry.kind        = kind;
      entry.motor_index = 3'(motor);
      entry.motor_value = value;
      entry.last        = is_last;
      due_results.push_back(entry);
   endfunction

   // Advance the receiver copy by one transfer and queue what it emits
   function automatic void decode_serial_item(input logic action, input logic [7:0] data_byte);
      int count;
      int check_pos;
      int slot;
      count = active_motor_count();
      if (action) begin
         if (tick_count != fmcr_pkg::ELAPSED_MAX) begin
            tick_count++;
         end
         if (tick_count > 17'(cfg_timeout)) begin
            frame_pos = '0;
            frame_xor = '0;
            if (!in_timeout) begin
               in_timeout = 1'b1;
               for (int m = 0; m < count; m++) begin
                  push_result(fmcr_pkg::KIND_NEUTRAL, m, cfg_neutral, m == count - 1);
               end
            end
         end
         return;
      end
      check_pos = 2 * count + 1;
      // Hunt for the start byte
      if (frame_pos == 5'd0) begin
         if (data_byte == cfg_start) begin
            frame_xor = data_byte;
            frame_pos = 5'd1;
         end
         return;
      end
      // Collect motor bytes, low byte first
      if (int'(frame_pos) < check_pos) begin
         frame_xor ^= data_byte;
         if (frame_pos[0]) begin
            held_low = data_byte;
         end else begin
            slot = (int'(frame_pos) - 2) / 2;
            if (slot < fmcr_pkg::MAX_MOTORS) begin
               motor_values[slot] = {data_byte, held_low};
            end
         end
         frame_pos++;
         return;
      end
      // Checksum byte closes the frame
      frame_pos = '0;
      if (data_byte != frame_xor) begin
         frame_xor = '0;
         push_result(fmcr_pkg::KIND_ERROR, 0, 16'd0, 1'b1);
         return;
      end
      frame_xor = '0;
      tick_count = '0;
      in_timeout = 1'b0;
      for (int m = 0; m < count; m++) begin
         push_result(fmcr_pkg::KIND_MOTOR, m, motor_values[m], m == count - 1);
      end
   endfunction

   // Drive the next transfer once the current one is taken
   always @(posedge clock) begin
      serial_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (serial_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item = serial_backlog.pop_front();
            req_valid     <= 1'b1;
            req_action    <= next_item.action;
            req_data_byte <= next_item.data_byte;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Predict on every accepted input transfer
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         decode_serial_item(req_action, req_data_byte);
      end
   end

   // Stall the result channel at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Check each result transfer against the oldest prediction
   always @(posedge clock) begin
      motor_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d index %0d value %h last %b",
                                      rsp_kind, rsp_motor_index, rsp_motor_value, rsp_last));
         end else begin
            want = due_results.pop_front();
            if (rsp_kind !== want.kind) begin
               report_mismatch($sformatf("kind %0d, expected %0d", rsp_kind, want.kind));
            end
            if (rsp_motor_index !== want.motor_index) begin
               report_mismatch($sformatf("motor_index %0d, expected %0d",
                                         rsp_motor_index, want.motor_index));
            end
            if (rsp_motor_value !== want.motor_value) begin
               report_mismatch($sformatf("motor_value %h, expected %h",
                                         rsp_motor_value, want.motor_value));
            end
            if (rsp_last !== want.last) begin
               report_mismatch($sformatf("last %b, expected %b", rsp_last, want.last));
            end
         end
      end
   end

   task automatic queue_byte(input logic [7:0] data_byte);
      serial_item_type entry;
      entry.action    = 1'b0;
      entry.data_byte = data_byte;
      serial_backlog.push_back(entry);
   endtask

   task automatic queue_tick();
      serial_item_type entry;
      entry.action    = 1'b1;
      entry.data_byte = 8'($urandom);
      serial_backlog.push_back(entry);
   endtask

   // Build one frame for the current settings, optionally broken
   task automatic queue_frame(input bit bad_sum, input bit tick_inside, input bit cut_short);
      int count;
      int byte_total;
      int tick_after;
      logic [15:0] value;
      logic [7:0] data_b;
      logic [7:0] sum;
      count = active_motor_count();
      byte_total = cut_short ? $urandom_range(0, 2 * count - 1) : 2 * count;
      tick_after = tick_inside ? $urandom_range(0, byte_total) : -1;
      value = 16'd0;
      sum = cfg_start;
      queue_byte(cfg_start);
      for (int j = 0; j < byte_total; j++) begin
         if (j == tick_after) begin
            queue_tick();
         end
         if (j % 2 == 0) begin
            case ($urandom_range(7))
               0: value = 16'h0000;
               1: value = 16'hFFFF;
               default: value = 16'($urandom);
            endcase
         end
         data_b = (j % 2 == 0) ? value[7:0] : value[15:8];
         sum ^= data_b;
         queue_byte(data_b);
      end
      if (!cut_short) begin
         if (tick_after == byte_total) begin
            queue_tick();
         end
         queue_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
      end
   endtask

   task automatic write_register(input fmcr_pkg::csr_index_type index,
                                 input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do begin
         @(posedge clock);
      end while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      case (index)
         fmcr_pkg::CSR_NUM_MOTORS: cfg_num_motors = value[3:0];
         fmcr_pkg::CSR_START_BYTE: cfg_start = value[7:0];
         fmcr_pkg::CSR_NEUTRAL:    cfg_neutral = value;
         fmcr_pkg::CSR_TIMEOUT:    cfg_timeout = value;
         default:                  cfg_num_motors = cfg_num_motors;
      endcase
   endtask

   // Hold until every transfer is taken and every result is out, then let the block settle
   task automatic wait_idle();
      while (serial_backlog.size() > 0 || req_valid || due_results.size() > 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [3:0]  num;
      logic [15:0] neutral;
      logic [15:0] timeout;
      logic [7:0]  start;
      int burst_max;
      int pick;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: full frame at reset settings, stray byte ahead of it
      send_idle_pct = 16;
      recv_stall_pct = 16;
      queue_byte(8'hA5);
      queue_frame(1'b0, 1'b0, 1'b0);
      wait_idle();

      // Directed: one motor, zero timeout, extreme start and neutral
      write_register(fmcr_pkg::CSR_NUM_MOTORS, 16'd1);
      write_register(fmcr_pkg::CSR_START_BYTE, 16'h00FF);
      write_register(fmcr_pkg::CSR_NEUTRAL, 16'hFFFF);
      write_register(fmcr_pkg::CSR_TIMEOUT, 16'd0);
      queue_frame(1'b1, 1'b0, 1'b0);
      queue_tick();
      queue_tick();
      queue_frame(1'b0, 1'b0, 1'b0);
      // Tick while a frame is open abandons it; the tail is dropped
      queue_byte(cfg_start);
      queue_tick();
      queue_byte(8'h00);
      queue_frame(1'b0, 1'b0, 1'b0);
      wait_idle();

      // Directed: shrink the motor count while a frame is open
      write_register(fmcr_pkg::CSR_NUM_MOTORS, 16'd4);
      queue_byte(cfg_start);
      queue_byte(8'h5A);
      queue_byte(8'hC3);
      wait_idle();
      write_register(fmcr_pkg::CSR_NUM_MOTORS, 16'd1);
      queue_byte(cfg_start ^ 8'h5A ^ 8'hC3);
      wait_idle();

      // Random phases over several settings and idling patterns
      for (int p = 0; p < 8; p++) begin
         start = 8'($urandom);
         neutral = 16'($urandom);
         case (p)
            0: begin num = 4'd1; start = 8'h00; neutral = 16'h0000; timeout = 16'd1; end
            1: begin num = 4'd8; start = 8'hFF; neutral = 16'hFFFF; timeout = 16'hFFFF; end
            2: begin num = 4'd0; timeout = 16'd2; end
            3: begin num = 4'd15; timeout = 16'd5; end
            4: begin num = 4'($urandom_range(1, 8)); timeout = 16'($urandom_range(0, 12)); end
            5: begin num = 4'd3; timeout = 16'd0; end
            6: begin num = 4'($urandom_range(0, 15)); timeout = 16'($urandom_range(0, 30)); end
            default: begin num = 4'd2; timeout = 16'd1000; end
         endcase
         write_register(fmcr_pkg::CSR_NUM_MOTORS, 16'(num));
         write_register(fmcr_pkg::CSR_START_BYTE, 16'(start));
         write_register(fmcr_pkg::CSR_NEUTRAL, neutral);
         write_register(fmcr_pkg::CSR_TIMEOUT, timeout);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         burst_max = (cfg_timeout < 16'd20) ? int'(cfg_timeout) + 2 : 8;
         // Half clean frames, the rest broken frames, noise and tick bursts
         while (serial_backlog.size() < 24) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
               queue_frame(1'b0, $urandom_range(4) == 0, 1'b0);
            end else if (pick < 65) begin
               queue_frame(1'b1, 1'b0, 1'b0);
            end else if (pick < 72) begin
               queue_frame(1'b0, 1'b0, 1'b1);
            end else if (pick < 82) begin
               repeat ($urandom_range(1, 3)) queue_byte(8'($urandom));
            end else begin
               repeat ($urandom_range(1, burst_max)) queue_tick();
            end
         end
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/fmcr_pkg.sv
sv/fmcr_store.sv
sv/fmcr_frame.sv
sv/fmcr_emit.sv
sv/framed_motor_command_receiver.sv
sim/framed_motor_command_receiver_tb.sv
